// ===== design/tis_pkg.sv =====
package tis_pkg;

  localparam int unsigned TimeW = 48;
  localparam int unsigned IdW   = 32;
  localparam int unsigned AccW  = 52;

  typedef enum logic [2:0] {
    REQ_TICK      = 3'd0,
    REQ_SET_TMO   = 3'd1,
    REQ_SET_IVL   = 3'd2,
    REQ_CLR_TMO   = 3'd3,
    REQ_CLR_IVL   = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    KIND_ID       = 3'd0,
    KIND_TMO_FIRE = 3'd1,
    KIND_IVL_FIRE = 3'd2,
    KIND_CLEAR    = 3'd3,
    KIND_TICK     = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IVL_RD,
    ST_IVL_WAIT,
    ST_IVL_UPD,
    ST_TMO_RD,
    ST_TMO_WAIT,
    ST_TMO_CHK,
    ST_SHIFT_RD,
    ST_SHIFT_WAIT,
    ST_SHIFT_WR,
    ST_FIND_RD,
    ST_FIND_WAIT,
    ST_FIND_CHK,
    ST_INS_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]       req_type;
    logic [TimeW-1:0] now_time;
    logic [TimeW-1:0] duration;
    logic [IdW-1:0]   timer_id;
  } req_t;

  typedef struct packed {
    logic [2:0]     kind;
    logic [IdW-1:0] result_id;
    logic           ok;
    logic           last;
  } rsp_t;

  // Timeout table entry: deadline and owner id.
  typedef struct packed {
    logic [TimeW-1:0] deadline;
    logic [IdW-1:0]   owner;
  } tmo_ent_t;

  // Interval table entry: period, accumulator and owner id.
  typedef struct packed {
    logic [TimeW-1:0] period;
    logic [AccW-1:0]  accum;
    logic [IdW-1:0]   owner;
  } ivl_ent_t;

endpackage

// ===== design/timeout_interval_scheduler.sv =====
// A set interval, a clear of id 0 or a timeout set on a full table goes straight to the
// last beat; a clear interval walks the interval table, a timeout set or clear searches
// the timeout table and shifts entries, and a tick walks the interval table, then shifts
// out each due timeout. One item at a time; busy is high through the last beat and the
// next start can be taken in the cycle after it. Each table is walked one entry per step.
// Reset clears counts, valid bits and time and sets the id counter to 2, not the memories.
module timeout_interval_scheduler #(
  parameter int unsigned TIMEOUT_SLOTS  = 16,
  parameter int unsigned INTERVAL_SLOTS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  tis_pkg::req_t req_i,
  output logic          strobe,
  output tis_pkg::rsp_t rsp_o
);
  import tis_pkg::*;

  localparam int unsigned TAw = (TIMEOUT_SLOTS > 1) ? $clog2(TIMEOUT_SLOTS) : 1;
  localparam int unsigned IAw = (INTERVAL_SLOTS > 1) ? $clog2(INTERVAL_SLOTS) : 1;
  localparam int unsigned TCw = $clog2(TIMEOUT_SLOTS + 1);
  localparam int unsigned ICw = $clog2(INTERVAL_SLOTS + 1);
  localparam int unsigned TmoW = $bits(tmo_ent_t);
  localparam int unsigned IvlW = $bits(ivl_ent_t);
  localparam logic [TCw-1:0] TFull = TCw'(TIMEOUT_SLOTS);
  localparam logic [ICw-1:0] IEnd  = ICw'(INTERVAL_SLOTS);

  state_e state_q, state_d;
  req_t   req_q, req_d;
  logic [TCw-1:0] cnt_q, cnt_d;
  logic [TCw-1:0] tidx_q, tidx_d;
  logic [TCw-1:0] shend_q, shend_d;
  logic           shup_q, shup_d;
  logic [ICw-1:0] iidx_q, iidx_d;
  logic [INTERVAL_SLOTS-1:0] live_q, live_d;
  logic [IdW-1:0]   idc_q, idc_d;
  logic [TimeW-1:0] prev_q, prev_d;
  logic             seen_q, seen_d;
  logic [TimeW-1:0] elap_q, elap_d;
  logic [TimeW-1:0] dl_q, dl_d;
  tmo_ent_t         hold_q, hold_d;
  logic             ok_q, ok_d;
  logic             strobe_q, strobe_d;
  rsp_t             rsp_q, rsp_d;
  logic             accept;

  // A request beat is taken only while the block is idle and no beat is out.
  assign accept = start && !busy;

  // Table memories.
  logic            t_we, i_we;
  logic [TAw-1:0]  t_wa, t_ra;
  logic [IAw-1:0]  i_wa, i_ra;
  tmo_ent_t        t_wd, t_rd;
  ivl_ent_t        i_wd, i_rd;
  logic [TmoW-1:0] t_rd_raw;
  logic [IvlW-1:0] i_rd_raw;

  tis_ram #(.Width(TmoW), .Depth(TIMEOUT_SLOTS)) u_tmo_ram (
    .clk_i, .we_i(t_we), .waddr_i(t_wa), .wdata_i(t_wd),
    .raddr_i(t_ra), .rdata_o(t_rd_raw)
  );
  tis_ram #(.Width(IvlW), .Depth(INTERVAL_SLOTS)) u_ivl_ram (
    .clk_i, .we_i(i_we), .waddr_i(i_wa), .wdata_i(i_wd),
    .raddr_i(i_ra), .rdata_o(i_rd_raw)
  );
  assign t_rd = tmo_ent_t'(t_rd_raw);
  assign i_rd = ivl_ent_t'(i_rd_raw);

  // Interval update arithmetic on the read entry.
  logic [AccW-1:0] acc_sum, acc_sub, acc_new, per_x10;
  logic            ivl_fire;
  assign acc_sum  = i_rd.accum + AccW'(elap_q);
  assign ivl_fire = acc_sum >= AccW'(i_rd.period);
  assign acc_sub  = ivl_fire ? acc_sum - AccW'(i_rd.period) : acc_sum;
  assign per_x10  = (AccW'(i_rd.period) << 3) + (AccW'(i_rd.period) << 1);
  assign acc_new  = (acc_sub > per_x10) ? '0 : acc_sub;

  logic [TimeW:0] dl_sum;
  assign dl_sum = {1'b0, req_q.now_time} + {1'b0, req_q.duration};

  logic [IdW-1:0] id_next;
  assign id_next = (idc_q == '1) ? IdW'(2) : idc_q + IdW'(1);

  // First free interval slot.
  logic [ICw-1:0] free_slot;
  always_comb begin
    free_slot = IEnd;
    for (int i = INTERVAL_SLOTS - 1; i >= 0; i--) begin
      if (!live_q[i]) begin
        free_slot = ICw'(i);
      end
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_i.req_type)
            REQ_TICK:    state_d = ST_IVL_RD;
            REQ_SET_TMO: state_d = (cnt_q >= TFull) ? ST_DONE : ST_FIND_RD;
            REQ_SET_IVL: state_d = ST_DONE;
            REQ_CLR_TMO: state_d = (req_i.timer_id == '0) ? ST_DONE : ST_FIND_RD;
            REQ_CLR_IVL: state_d = (req_i.timer_id == '0) ? ST_DONE : ST_IVL_RD;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_IVL_RD:   state_d = (iidx_q >= IEnd) ?
                     ((req_q.req_type == REQ_TICK) ? ST_TMO_RD : ST_DONE) : ST_IVL_WAIT;
      ST_IVL_WAIT: state_d = ST_IVL_UPD;
      ST_IVL_UPD: begin
        if (req_q.req_type == REQ_CLR_IVL && live_q[iidx_q[IAw-1:0]] &&
            i_rd.owner == req_q.timer_id) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_IVL_RD;
        end
      end
      ST_TMO_RD:   state_d = (cnt_q == '0) ? ST_DONE : ST_TMO_WAIT;
      ST_TMO_WAIT: state_d = ST_TMO_CHK;
      ST_TMO_CHK:  state_d = (t_rd.deadline <= req_q.now_time) ? ST_SHIFT_RD : ST_DONE;
      ST_SHIFT_RD: state_d = (!shup_q && tidx_q >= shend_q) ? ST_SHIFT_WR : ST_SHIFT_WAIT;
      ST_SHIFT_WAIT: state_d = ST_SHIFT_WR;
      ST_SHIFT_WR: begin
        if (shup_q) begin
          state_d = (tidx_q <= dl_q[TCw-1:0]) ? ST_INS_WR : ST_SHIFT_RD;
        end else if (tidx_q >= shend_q) begin
          state_d = (req_q.req_type == REQ_TICK) ? ST_TMO_RD : ST_DONE;
        end else begin
          state_d = ST_SHIFT_RD;
        end
      end
      ST_FIND_RD:   state_d = (tidx_q >= cnt_q) ?
                      ((req_q.req_type == REQ_SET_TMO) ? ST_SHIFT_RD : ST_DONE) : ST_FIND_WAIT;
      ST_FIND_WAIT: state_d = ST_FIND_CHK;
      ST_FIND_CHK: begin
        if (req_q.req_type == REQ_SET_TMO) begin
          state_d = (t_rd.deadline <= dl_q) ? ST_FIND_RD : ST_SHIFT_RD;
        end else begin
          state_d = (t_rd.owner == req_q.timer_id) ? ST_SHIFT_RD : ST_FIND_RD;
        end
      end
      ST_INS_WR: state_d = ST_DONE;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath, memory controls and result beats.
  always_comb begin
    req_d = req_q; cnt_d = cnt_q; tidx_d = tidx_q; shend_d = shend_q; shup_d = shup_q;
    iidx_d = iidx_q; live_d = live_q; idc_d = idc_q; prev_d = prev_q; seen_d = seen_q;
    elap_d = elap_q; dl_d = dl_q; hold_d = hold_q; ok_d = ok_q;
    strobe_d = 1'b0; rsp_d = rsp_q;
    t_we = 1'b0; t_wa = tidx_q[TAw-1:0]; t_wd = hold_q; t_ra = tidx_q[TAw-1:0];
    i_we = 1'b0; i_wa = iidx_q[IAw-1:0]; i_wd = i_rd; i_ra = iidx_q[IAw-1:0];
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d = req_i; iidx_d = '0; tidx_d = '0; ok_d = 1'b0;
          elap_d = (seen_q && req_i.now_time > prev_q) ? req_i.now_time - prev_q : '0;
          if (req_i.req_type == REQ_SET_IVL && free_slot < IEnd) begin
            i_we = 1'b1; i_wa = free_slot[IAw-1:0];
            i_wd.period = req_i.duration; i_wd.accum = '0; i_wd.owner = idc_q;
            live_d[free_slot[IAw-1:0]] = 1'b1;
            hold_d.owner = idc_q; ok_d = 1'b1; idc_d = id_next;
          end
          if ((req_i.req_type == REQ_CLR_TMO || req_i.req_type == REQ_CLR_IVL) &&
              req_i.timer_id == '0) begin
            ok_d = 1'b1;
          end
        end
      end
      ST_IVL_UPD: begin
        if (req_q.req_type == REQ_TICK) begin
          if (live_q[iidx_q[IAw-1:0]]) begin
            i_we = 1'b1; i_wd.accum = acc_new;
            if (ivl_fire) begin
              strobe_d = 1'b1;
              rsp_d = '{kind: KIND_IVL_FIRE, result_id: i_rd.owner, ok: 1'b1, last: 1'b0};
            end
          end
        end else if (live_q[iidx_q[IAw-1:0]] && i_rd.owner == req_q.timer_id) begin
          live_d[iidx_q[IAw-1:0]] = 1'b0; ok_d = 1'b1;
        end
        iidx_d = iidx_q + ICw'(1);
      end
      ST_TMO_RD: begin
        t_ra = '0; tidx_d = '0;
      end
      ST_TMO_CHK: begin
        if (t_rd.deadline <= req_q.now_time) begin
          strobe_d = 1'b1;
          rsp_d = '{kind: KIND_TMO_FIRE, result_id: t_rd.owner, ok: 1'b1, last: 1'b0};
          shup_d = 1'b0; shend_d = cnt_q - TCw'(1); tidx_d = '0;
        end
      end
      // Shift one entry: down (removal) reads idx+1 into idx, up reads idx-1 into idx.
      // The address is held through the wait cycle so the data is valid at the write.
      ST_SHIFT_RD, ST_SHIFT_WAIT: begin
        t_ra = shup_q ? TAw'(tidx_q - TCw'(1)) : TAw'(tidx_q + TCw'(1));
      end
      ST_SHIFT_WR: begin
        if (shup_q) begin
          if (tidx_q > dl_q[TCw-1:0]) begin
            t_we = 1'b1; t_wd = t_rd; tidx_d = tidx_q - TCw'(1);
          end else begin
            tidx_d = dl_q[TCw-1:0];
          end
        end else if (tidx_q >= shend_q) begin
          cnt_d = cnt_q - TCw'(1);
        end else begin
          t_we = 1'b1; t_wd = t_rd; tidx_d = tidx_q + TCw'(1);
        end
      end
      ST_FIND_RD: begin
        if (req_q.req_type == REQ_SET_TMO && tidx_q == '0) begin
          dl_d = dl_sum[TimeW] ? '1 : dl_sum[TimeW-1:0];
        end
        if (tidx_q >= cnt_q && req_q.req_type == REQ_SET_TMO) begin
          hold_d = '{deadline: dl_d, owner: idc_q};
          shup_d = 1'b1; dl_d = TimeW'(tidx_q); tidx_d = cnt_q;
        end
      end
      ST_FIND_CHK: begin
        if (req_q.req_type == REQ_SET_TMO) begin
          if (t_rd.deadline <= dl_q) begin
            tidx_d = tidx_q + TCw'(1);
          end else begin
            hold_d = '{deadline: dl_q, owner: idc_q};
            shup_d = 1'b1; dl_d = TimeW'(tidx_q); tidx_d = cnt_q;
          end
        end else if (t_rd.owner == req_q.timer_id) begin
          ok_d = 1'b1; shup_d = 1'b0; shend_d = cnt_q - TCw'(1);
        end else begin
          tidx_d = tidx_q + TCw'(1);
        end
      end
      ST_INS_WR: begin
        t_we = 1'b1; t_wa = dl_q[TAw-1:0]; t_wd = hold_q;
        cnt_d = cnt_q + TCw'(1); idc_d = id_next; ok_d = 1'b1;
      end
      ST_DONE: begin
        strobe_d = 1'b1;
        case (req_q.req_type)
          REQ_TICK: begin
            rsp_d = '{kind: KIND_TICK, result_id: '0, ok: 1'b1, last: 1'b1};
            prev_d = req_q.now_time; seen_d = 1'b1;
          end
          REQ_SET_TMO, REQ_SET_IVL:
            rsp_d = '{kind: KIND_ID, result_id: ok_q ? hold_q.owner : '0, ok: ok_q,
                      last: 1'b1};
          default:
            rsp_d = '{kind: KIND_CLEAR, result_id: req_q.timer_id, ok: ok_q, last: 1'b1};
        endcase
      end
      default: ;
    endcase
  end

  // The stored id of a set timeout is taken from hold_q at insert time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; cnt_q <= '0; live_q <= '0; idc_q <= IdW'(2);
      prev_q <= '0; seen_q <= 1'b0; strobe_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; live_q <= live_d; idc_q <= idc_d;
      prev_q <= prev_d; seen_q <= seen_d; strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; tidx_q <= tidx_d; shend_q <= shend_d; shup_q <= shup_d;
    iidx_q <= iidx_d; elap_q <= elap_d; dl_q <= dl_d; hold_q <= hold_d;
    ok_q <= ok_d; rsp_q <= rsp_d;
  end

  assign busy   = (state_q != ST_IDLE) || strobe_q;
  assign strobe = strobe_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= TFull) else $error("timeout count beyond table size");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> busy) else $error("busy low while working");
  a_done_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |=> (strobe && rsp_o.last)) else $error("missing last beat");
`endif

endmodule

// ===== design/tis_ram.sv =====
module tis_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                            wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                            rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import tis_pkg::*;

  localparam int unsigned NumTmo = 16;
  localparam int unsigned NumIvl = 16;
  localparam logic [47:0] TimeMax = 48'hFFFF_FFFF_FFFF;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic strobe;
  rsp_t rsp_o;

  timeout_interval_scheduler u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .strobe (strobe),
    .rsp_o  (rsp_o)
  );

  // Shadow copy of the scheduler state.
  logic [47:0] sh_deadline [NumTmo];
  logic [31:0] sh_downer [NumTmo];
  int unsigned sh_pending;
  logic [47:0] sh_period [NumIvl];
  logic [51:0] sh_accum [NumIvl];
  logic [31:0] sh_powner [NumIvl];
  logic        sh_live [NumIvl];
  logic [31:0] sh_next_id;
  logic [47:0] sh_prev_time;
  logic        sh_seen;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  logic [31:0] issued_ids[$];
  int unsigned errors;
  int unsigned gap;
  logic        hold_off;

  always #6 clk_i = ~clk_i;

  function automatic logic [31:0] grab_id();
    logic [31:0] id;
    id = sh_next_id;
    sh_next_id = (sh_next_id == 32'hFFFF_FFFF) ? 32'd2 : sh_next_id + 32'd1;
    return id;
  endfunction

  function automatic void push_rsp(kind_e k, logic [31:0] id, logic ok);
    rsp_t r;
    r.kind = k;
    r.result_id = id;
    r.ok = ok;
    r.last = 1'b0;
    expected_rsps.push_back(r);
  endfunction

  function automatic void drop_deadline(int unsigned pos);
    for (int unsigned i = pos; i + 1 < sh_pending; i++) begin
      sh_deadline[i] = sh_deadline[i+1];
      sh_downer[i] = sh_downer[i+1];
    end
    sh_pending--;
  endfunction

  // Work out the result beats of one request and update the shadow state.
  function automatic void schedule_step(req_t rq);
    int unsigned n_prior;
    logic [47:0] elapsed;
    logic [51:0] acc;
    logic [51:0] p;
    logic [48:0] dl;
    logic [31:0] id;
    int unsigned pos;
    int slot;
    logic ok;
    n_prior = expected_rsps.size();
    case (rq.req_type)
      REQ_TICK: begin
        elapsed = (sh_seen && rq.now_time > sh_prev_time) ? rq.now_time - sh_prev_time : '0;
        for (int i = 0; i < NumIvl; i++) begin
          if (sh_live[i]) begin
            p = {4'd0, sh_period[i]};
            acc = sh_accum[i] + {4'd0, elapsed};
            if (acc >= p) begin
              acc = acc - p;
              push_rsp(KIND_IVL_FIRE, sh_powner[i], 1'b1);
            end
            if ({4'd0, acc} > {4'd0, p} * 56'd10) acc = '0;
            sh_accum[i] = acc;
          end
        end
        while (sh_pending > 0 && sh_deadline[0] <= rq.now_time) begin
          push_rsp(KIND_TMO_FIRE, sh_downer[0], 1'b1);
          drop_deadline(0);
        end
        push_rsp(KIND_TICK, '0, 1'b1);
        sh_prev_time = rq.now_time;
        sh_seen = 1'b1;
      end
      REQ_SET_TMO: begin
        if (sh_pending >= NumTmo) begin
          push_rsp(KIND_ID, '0, 1'b0);
        end else begin
          dl = {1'b0, rq.now_time} + {1'b0, rq.duration};
          if (dl[48]) dl = {1'b0, TimeMax};
          id = grab_id();
          pos = 0;
          while (pos < sh_pending && sh_deadline[pos] <= dl[47:0]) pos++;
          for (int unsigned i = sh_pending; i > pos; i--) begin
            sh_deadline[i] = sh_deadline[i-1];
            sh_downer[i] = sh_downer[i-1];
          end
          sh_deadline[pos] = dl[47:0];
          sh_downer[pos] = id;
          sh_pending++;
          push_rsp(KIND_ID, id, 1'b1);
          issued_ids.push_back(id);
        end
      end
      REQ_SET_IVL: begin
        slot = -1;
        for (int i = NumIvl - 1; i >= 0; i--) if (!sh_live[i]) slot = i;
        if (slot < 0) begin
          push_rsp(KIND_ID, '0, 1'b0);
        end else begin
          id = grab_id();
          sh_live[slot] = 1'b1;
          sh_period[slot] = rq.duration;
          sh_accum[slot] = '0;
          sh_powner[slot] = id;
          push_rsp(KIND_ID, id, 1'b1);
          issued_ids.push_back(id);
        end
      end
      REQ_CLR_TMO: begin
        ok = (rq.timer_id == '0);
        if (!ok) begin
          for (int unsigned i = 0; i < sh_pending; i++) begin
            if (!ok && sh_downer[i] == rq.timer_id) begin
              drop_deadline(i);
              ok = 1'b1;
            end
          end
        end
        push_rsp(KIND_CLEAR, rq.timer_id, ok);
      end
      REQ_CLR_IVL: begin
        ok = (rq.timer_id == '0);
        if (!ok) begin
          for (int i = 0; i < NumIvl; i++) begin
            if (!ok && sh_live[i] && sh_powner[i] == rq.timer_id) begin
              sh_live[i] = 1'b0;
              ok = 1'b1;
            end
          end
        end
        push_rsp(KIND_CLEAR, rq.timer_id, ok);
      end
      default: ;
    endcase
    if (expected_rsps.size() > n_prior) expected_rsps[$].last = 1'b1;
  endfunction

  // Driver: one request beat per start pulse, with random gaps.
  // A start raised while busy is low is always taken at the next rising edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start) begin
        start <= 1'b0;
        gap <= $urandom_range(0, 5);
      end else if (!busy) begin
        if (gap != 0) begin
          gap <= gap - 1;
        end else if (pending_reqs.size() != 0 && !(hold_off && expected_rsps.size() != 0)) begin
          req_i <= pending_reqs[0];
          schedule_step(pending_reqs.pop_front());
          start <= 1'b1;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && strobe) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected beat %h", $realtime, rsp_o);
        errors++;
      end else begin
        if (rsp_o.kind !== expected_rsps[0].kind ||
            rsp_o.result_id !== expected_rsps[0].result_id ||
            rsp_o.ok !== expected_rsps[0].ok || rsp_o.last !== expected_rsps[0].last) begin
          $display("%0t: mismatch expected kind %0d id %h ok %b last %b, got kind %0d id %h ok %b last %b",
                   $realtime, expected_rsps[0].kind, expected_rsps[0].result_id,
                   expected_rsps[0].ok, expected_rsps[0].last, rsp_o.kind,
                   rsp_o.result_id, rsp_o.ok, rsp_o.last);
          errors++;
        end
        void'(expected_rsps.pop_front());
      end
    end
  end

  function automatic req_t make_req(req_e t, logic [47:0] now, logic [47:0] dur,
                                    logic [31:0] id);
    req_t r;
    r.req_type = t;
    r.now_time = now;
    r.duration = dur;
    r.timer_id = id;
    return r;
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()} >> 16);
  endfunction

  // Random id: mostly one that was issued, sometimes zero or noise.
  function automatic logic [31:0] pick_id();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1 || issued_ids.size() == 0) return $urandom();
    return issued_ids[$urandom_range(0, issued_ids.size() - 1)] + ((sel == 2) ? 32'd0 : 32'd0);
  endfunction

  initial begin
    logic [47:0] t;
    req_t r;
    int unsigned sel;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    gap = 0;
    hold_off = 1'b0;
    errors = 0;
    sh_pending = 0;
    sh_next_id = 32'd2;
    sh_prev_time = '0;
    sh_seen = 1'b0;
    for (int i = 0; i < NumIvl; i++) sh_live[i] = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: first tick, zero clears, unknown ids, saturation,
    // equal deadlines, zero period, backwards time and unknown types.
    pending_reqs.push_back(make_req(REQ_TICK, 48'd1000, '0, '0));
    pending_reqs.push_back(make_req(REQ_CLR_TMO, '0, '0, '0));
    pending_reqs.push_back(make_req(REQ_CLR_IVL, '0, '0, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(REQ_SET_TMO, TimeMax, TimeMax, '0));
    pending_reqs.push_back(make_req(REQ_SET_TMO, 48'd1000, 48'd50, '0));
    pending_reqs.push_back(make_req(REQ_SET_TMO, 48'd1010, 48'd40, '0));
    pending_reqs.push_back(make_req(REQ_SET_IVL, '0, 48'd0, '0));
    pending_reqs.push_back(make_req(REQ_SET_IVL, '0, 48'd1, '0));
    pending_reqs.push_back(make_req(REQ_SET_IVL, '0, 48'd100, '0));
    pending_reqs.push_back(make_req(REQ_TICK, 48'd1050, '0, '0));
    pending_reqs.push_back(make_req(REQ_TICK, 48'd900, '0, '0));
    pending_reqs.push_back(make_req(REQ_TICK, 48'd5000, '0, '0));
    pending_reqs.push_back(make_req(REQ_SET_IVL, '0, TimeMax, '0));
    pending_reqs.push_back(make_req(REQ_CLR_IVL, '0, '0, 32'd8));
    pending_reqs.push_back(make_req(REQ_CLR_IVL, '0, '0, 32'd8));
    pending_reqs.push_back(make_req(REQ_CLR_TMO, '0, '0, 32'd2));
    pending_reqs.push_back(make_req(req_e'(3'd5), rand48(), '0, '0));
    pending_reqs.push_back(make_req(req_e'(3'd7), TimeMax, TimeMax, 32'hFFFF_FFFF));
    // Fill both tables to overflow.
    for (int i = 0; i < 17; i++)
      pending_reqs.push_back(make_req(REQ_SET_TMO, 48'd6000, 48'(10 + i % 3), '0));
    for (int i = 0; i < 15; i++)
      pending_reqs.push_back(make_req(REQ_SET_IVL, '0, 48'(500 + i), '0));
    pending_reqs.push_back(make_req(REQ_TICK, 48'd7000, '0, '0));
    while (pending_reqs.size() != 0) @(negedge clk_i);

    // Pause until every expected beat has come.
    hold_off = 1'b1;
    wait (expected_rsps.size() == 0);
    @(negedge clk_i);
    hold_off = 1'b0;

    // Random part: mostly well-formed traffic with monotonic time.
    t = 48'd8000;
    for (int n = 0; n < 100; n++) begin
      sel = $urandom_range(0, 19);
      if (sel < 6) begin
        t = (sel == 0) ? t + rand48() % 48'h1000_0000 : t + 48'($urandom_range(0, 800));
        if (sel == 1 && n % 30 == 0) t = TimeMax;
        r = make_req(REQ_TICK, (sel == 2) ? t - 48'd300 : t, rand48(), $urandom());
      end else if (sel < 10) begin
        r = make_req(REQ_SET_TMO, (sel == 6) ? rand48() : t,
                     (sel == 7) ? rand48() : 48'($urandom_range(1, 2000)), $urandom());
      end else if (sel < 13) begin
        r = make_req(REQ_SET_IVL, rand48(),
                     (sel == 10) ? rand48() : 48'($urandom_range(0, 900)), $urandom());
      end else if (sel < 16) begin
        r = make_req(REQ_CLR_TMO, rand48(), rand48(), pick_id());
      end else if (sel < 19) begin
        r = make_req(REQ_CLR_IVL, rand48(), rand48(), pick_id());
      end else begin
        r = make_req(req_e'(3'($urandom_range(5, 7))), rand48(), rand48(), $urandom());
      end
      pending_reqs.push_back(r);
    end
    while (pending_reqs.size() != 0 || start || busy) @(negedge clk_i);
    wait (expected_rsps.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
design/tis_pkg.sv
design/tis_ram.sv
design/timeout_interval_scheduler.sv
verif/testbench.sv
